// ===== hdl/lge_pkg.sv =====
// lge_pkg: shared types and constants for the life grid engine
// no dependencies; used by lge_row_mem, lge_cell_unit, the top level and the testbench files

package lge_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 6;
  localparam int COUNT_W   = 4;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(64);

  localparam logic [COUNT_W-1:0] SURVIVE_CNT = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] BIRTH_CNT   = COUNT_W'(3);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_READ   = 2'd2,
    OP_STEP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_value;
  } cmd_t;

  typedef struct packed {
    logic alive;
    logic in_range;
  } rsp_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

// ===== hdl/lge_stream_if.sv =====
// lge_stream_if: valid/ready channel carrying one request or result
// payload type is given by the instantiating level (lge_pkg types)

interface lge_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/lge_row_mem.sv =====
// lge_row_mem: grid storage, one row of cells per word
// one write port, one read port with registered read data; uses lge_pkg

module lge_row_mem #(
  parameter int DEPTH = lge_pkg::DEF_MAX_ROWS,
  parameter int WIDTH = lge_pkg::DEF_MAX_COLS
) (
  input  logic                     clk,
  input  lge_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lge_cell_unit.sv =====
// lge_cell_unit: shared B3/S23 rule unit for one cell of a three-row window
// picks the column, counts live neighbors, applies the rule; uses lge_pkg

module lge_cell_unit #(
  parameter int COLS = lge_pkg::DEF_MAX_COLS,
  parameter int EW   = 8
) (
  input  logic [COLS-1:0]         above,
  input  logic [COLS-1:0]         cur,
  input  logic [COLS-1:0]         below,
  input  logic [$clog2(COLS)-1:0] col,
  input  logic [EW-1:0]           ncols,
  output logic                    next_bit
);

  localparam int CAW = $clog2(COLS);

  logic                         has_left;
  logic                         has_right;
  logic [CAW-1:0]               lidx;
  logic [CAW-1:0]               ridx;
  logic [7:0]                   nbr;
  logic [lge_pkg::COUNT_W-1:0]  count;

  assign has_left  = (col != '0);
  assign has_right = ((EW'(col) + EW'(1)) < ncols);
  assign lidx      = col - CAW'(1);
  assign ridx      = col + CAW'(1);

  always_comb begin
    nbr[0] = has_left  ? above[lidx] : 1'b0;
    nbr[1] = above[col];
    nbr[2] = has_right ? above[ridx] : 1'b0;
    nbr[3] = has_left  ? cur[lidx]   : 1'b0;
    nbr[4] = has_right ? cur[ridx]   : 1'b0;
    nbr[5] = has_left  ? below[lidx] : 1'b0;
    nbr[6] = below[col];
    nbr[7] = has_right ? below[ridx] : 1'b0;
    count  = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + lge_pkg::COUNT_W'(nbr[i]);
    end
  end

  assign next_bit = (count == lge_pkg::BIRTH_CNT) ||
                    (cur[col] && (count == lge_pkg::SURVIVE_CNT));

endmodule

// ===== hdl/life_automaton_grid_engine_top.sv =====
// life_automaton_grid_engine_top: bounded B3/S23 life grid with cell access
// cell write/toggle/read: S_CELL then S_FINISH (only S_FINISH when out of range)
// generation step: S_LOAD, then S_FILL/S_CALC/S_ROW_END per row, one cell per cycle
// one request at a time; a result waits in the output register while the next runs
// synchronous reset, then a clearing pass over all MAX_ROWS rows, one row per cycle
// uses lge_pkg, lge_stream_if, lge_row_mem, lge_cell_unit

module life_automaton_grid_engine_top #(
  parameter int MAX_ROWS = lge_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lge_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  lge_stream_if.sink                    cmd,
  lge_stream_if.source                  result,
  input  logic                          wr_en,
  input  logic [lge_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lge_pkg::CFG_W-1:0]     wr_data
);

  localparam int RAW = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int AWM = (RAW > CAW) ? RAW : CAW;
  localparam int EW  = ((AWM > lge_pkg::CFG_W - 1) ? AWM : lge_pkg::CFG_W - 1) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_LOAD,
    S_FILL,
    S_CALC,
    S_ROW_END,
    S_FINISH
  } state_t;

  state_t                    state;
  logic [lge_pkg::CFG_W-1:0] rows_in_use;
  logic [lge_pkg::CFG_W-1:0] cols_in_use;
  logic [RAW-1:0]            r;
  logic [CAW-1:0]            c;
  logic [RAW-1:0]            row_q;
  logic [CAW-1:0]            col_q;
  lge_pkg::op_t              op;
  logic                      val;
  logic [MAX_COLS-1:0]       above;
  logic [MAX_COLS-1:0]       cur;
  logic [MAX_COLS-1:0]       below;
  logic [MAX_COLS-1:0]       nxt;
  logic                      res_alive;
  logic                      res_in_range;
  logic                      out_valid;
  lge_pkg::rsp_t             out_rsp;

  logic [EW-1:0]             nr;
  logic [EW-1:0]             nc;
  logic                      accept;
  logic                      cmd_in_range;
  logic                      cell_old;
  logic                      cell_new;
  logic [MAX_COLS-1:0]       cell_row;
  logic                      rule_bit;
  lge_pkg::mem_ctl_t         mem_ctl;
  logic [RAW-1:0]            rd_addr;
  logic [RAW-1:0]            wr_addr;
  logic [MAX_COLS-1:0]       mem_wdata;
  logic [MAX_COLS-1:0]       mem_rdata;

  assign nr = (EW'(rows_in_use) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : EW'(rows_in_use);
  assign nc = (EW'(cols_in_use) > EW'(MAX_COLS)) ? EW'(MAX_COLS) : EW'(cols_in_use);

  assign cmd.ready      = (state == S_IDLE);
  assign accept         = cmd.valid && cmd.ready;
  assign cmd_in_range   = (EW'(cmd.payload.row) < nr) && (EW'(cmd.payload.col) < nc);
  assign result.valid   = out_valid;
  assign result.payload = out_rsp;

  // single cell update
  always_comb begin
    cell_old = mem_rdata[col_q];
    case (op)
      lge_pkg::OP_WRITE:  cell_new = val;
      lge_pkg::OP_TOGGLE: cell_new = ~cell_old;
      default:            cell_new = cell_old;
    endcase
    cell_row        = mem_rdata;
    cell_row[col_q] = cell_new;
  end

  // memory port control
  always_comb begin
    mem_ctl   = '0;
    rd_addr   = '0;
    wr_addr   = r;
    mem_wdata = nxt;
    case (state)
      S_CLEAR: begin
        mem_ctl.wr = 1'b1;
        mem_wdata  = '0;
      end
      S_IDLE: begin
        mem_ctl.rd = accept;
        rd_addr    = (cmd.payload.opcode == lge_pkg::OP_STEP) ? '0 : RAW'(cmd.payload.row);
      end
      S_LOAD: begin
        mem_ctl.rd = 1'b1;
        rd_addr    = RAW'(1);
      end
      S_CELL: begin
        mem_ctl.wr = (op != lge_pkg::OP_READ);
        wr_addr    = row_q;
        mem_wdata  = cell_row;
      end
      S_ROW_END: begin
        mem_ctl.wr = 1'b1;
        mem_ctl.rd = 1'b1;
        rd_addr    = r + RAW'(2);
      end
      default: begin
      end
    endcase
  end

  lge_row_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLS)
  ) u_row_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  lge_cell_unit #(
    .COLS (MAX_COLS),
    .EW   (EW)
  ) u_cell_unit (
    .above    (above),
    .cur      (cur),
    .below    (below),
    .col      (c),
    .ncols    (nc),
    .next_bit (rule_bit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      r           <= '0;
      out_valid   <= 1'b0;
      rows_in_use <= lge_pkg::ROWS_RESET;
      cols_in_use <= lge_pkg::COLS_RESET;
    end else begin
      if (wr_en) begin
        case (wr_index)
          lge_pkg::REG_ROWS_IN_USE: rows_in_use <= wr_data;
          lge_pkg::REG_COLS_IN_USE: cols_in_use <= wr_data;
          default: begin
          end
        endcase
      end
      if (out_valid && result.ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (r == RAW'(MAX_ROWS - 1)) begin
            r     <= '0;
            state <= S_IDLE;
          end else begin
            r <= r + RAW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            op    <= cmd.payload.opcode;
            val   <= cmd.payload.cell_value;
            row_q <= RAW'(cmd.payload.row);
            col_q <= CAW'(cmd.payload.col);
            r     <= '0;
            if (cmd.payload.opcode == lge_pkg::OP_STEP) begin
              res_alive    <= 1'b0;
              res_in_range <= 1'b1;
              if ((nr == '0) || (nc == '0)) begin
                state <= S_FINISH;
              end else begin
                state <= S_LOAD;
              end
            end else if (!cmd_in_range) begin
              res_alive    <= 1'b0;
              res_in_range <= 1'b0;
              state        <= S_FINISH;
            end else begin
              state <= S_CELL;
            end
          end
        end
        S_CELL: begin
          res_alive    <= cell_new;
          res_in_range <= 1'b1;
          state        <= S_FINISH;
        end
        S_LOAD: begin
          above <= '0;
          cur   <= mem_rdata;
          state <= S_FILL;
        end
        S_FILL: begin
          below <= ((EW'(r) + EW'(1)) < nr) ? mem_rdata : '0;
          nxt   <= cur;
          c     <= '0;
          state <= S_CALC;
        end
        S_CALC: begin
          nxt[c] <= rule_bit;
          if ((EW'(c) + EW'(1)) == nc) begin
            state <= S_ROW_END;
          end else begin
            c <= c + CAW'(1);
          end
        end
        S_ROW_END: begin
          above <= cur;
          cur   <= below;
          r     <= r + RAW'(1);
          if ((EW'(r) + EW'(1)) == nr) begin
            state <= S_FINISH;
          end else begin
            state <= S_FILL;
          end
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid        <= 1'b1;
            out_rsp.alive    <= res_alive;
            out_rsp.in_range <= res_in_range;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lge_checker.sv =====
// lge_checker: port-level checks of the life grid engine over time
// bound to life_automaton_grid_engine_top; uses no other file

module lge_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_alive,
  input logic rsp_in_range
);

  // no request taken right after reset while the grid is cleared
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("request ready right after reset");

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready held after a request was taken");

  // an out-of-range access never reports a live cell
  a_range_dead: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_in_range || !rsp_alive))
    else $error("live cell reported out of range");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

endmodule

bind life_automaton_grid_engine_top lge_checker u_lge_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .rsp_valid    (result.valid),
  .rsp_ready    (result.ready),
  .rsp_alive    (result.payload.alive),
  .rsp_in_range (result.payload.in_range)
);

// ===== tb/sv/lge_grid_checker.sv =====
// lge_grid_checker: watches the request, result and register write ports of the life grid engine
// keeps its own copy of the grid and grid size, predicts each result and compares it
// depends on lge_pkg

module lge_grid_checker
  import lge_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic                 cmd_ready,
  input  cmd_t                 cmd_payload,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rsp_t                 rsp_payload,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output int                   mismatches,
  output int                   pending
);

  bit [DEF_MAX_COLS-1:0] grid [DEF_MAX_ROWS];
  logic [CFG_W-1:0]      rows_cfg;
  logic [CFG_W-1:0]      cols_cfg;
  rsp_t                  rsp_q [$];
  int                    fail_cnt = 0;
  int                    checked  = 0;
  int                    open_cnt = 0;

  assign mismatches = fail_cnt;
  assign pending    = open_cnt;

  task automatic report(string what, int want, int got);
    $display("[%0t] mismatch on result %0d: %s expected %0d got %0d",
             $time, checked, what, want, got);
    fail_cnt++;
  endtask

  function automatic int rows_active();
    return (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_cfg);
  endfunction

  function automatic int cols_active();
    return (cols_cfg > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_cfg);
  endfunction

  function automatic void advance_generation();
    bit [DEF_MAX_COLS-1:0] nxt [DEF_MAX_ROWS];
    int nr;
    int nc;
    int n;
    int rr;
    int cc;
    nr = rows_active();
    nc = cols_active();
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
              n += grid[rr][cc];
          end
        end
        if (grid[r][c])
          nxt[r][c] = (n == int'(SURVIVE_CNT)) || (n == int'(BIRTH_CNT));
        else
          nxt[r][c] = (n == int'(BIRTH_CNT));
      end
    end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        grid[r][c] = nxt[r][c];
  endfunction

  function automatic rsp_t apply_request(cmd_t req);
    rsp_t res;
    res.alive    = 1'b0;
    res.in_range = 1'b1;
    if (req.opcode == OP_STEP) begin
      advance_generation();
    end else if (int'(req.row) >= rows_active() || int'(req.col) >= cols_active()) begin
      res.in_range = 1'b0;
    end else begin
      case (req.opcode)
        OP_WRITE:  grid[req.row][req.col] = req.cell_value;
        OP_TOGGLE: grid[req.row][req.col] = ~grid[req.row][req.col];
        default:   ;
      endcase
      res.alive = grid[req.row][req.col];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (grid[r]) grid[r] = '0;
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      rsp_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_ROWS_IN_USE: rows_cfg = wr_data;
          REG_COLS_IN_USE: cols_cfg = wr_data;
          default:         ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (rsp_q.size() == 0) begin
          report("unrequested result, alive/in_range", 0,
                 {30'd0, rsp_payload.alive, rsp_payload.in_range});
        end else begin
          want = rsp_q.pop_front();
          if (rsp_payload.alive !== want.alive)
            report("alive", want.alive, rsp_payload.alive);
          if (rsp_payload.in_range !== want.in_range)
            report("in_range", want.in_range, rsp_payload.in_range);
        end
        checked++;
      end
      if (cmd_valid && cmd_ready)
        rsp_q.push_back(apply_request(cmd_payload));
    end
    open_cnt = rsp_q.size();
  end

endmodule

// ===== tb/sv/tb_life_automaton_grid_engine_top.sv =====
// tb_life_automaton_grid_engine_top: drives requests, grid size writes and result stalls
// into the life grid engine; lge_grid_checker predicts and compares beside it
// depends on lge_pkg, lge_stream_if, life_automaton_grid_engine_top, lge_grid_checker

module tb_life_automaton_grid_engine_top;
  import lge_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = CFG_IDX_W'(3);

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;
  int                   mismatches;
  int                   pending;
  bit                   quiet = 1'b0;
  int                   ready_hold = 0;
  int                   rows_now = 64;
  int                   cols_now = 64;
  int                   n_write = 0;
  int                   n_toggle = 0;
  int                   n_read = 0;
  int                   n_step = 0;
  int                   n_sizes = 1;

  lge_stream_if #(.T(cmd_t)) cmd_ch ();
  lge_stream_if #(.T(rsp_t)) rsp_ch ();

  life_automaton_grid_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .result   (rsp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  lge_grid_checker grid_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_ch.valid),
    .cmd_ready   (cmd_ch.ready),
    .cmd_payload (cmd_ch.payload),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_payload (rsp_ch.payload),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic int pick_size();
    int w;
    w = $urandom_range(0, 99);
    if (w < 70) return $urandom_range(1, 12);
    if (w < 82) return 64;
    if (w < 90) return $urandom_range(65, 127);
    if (w < 95) return 0;
    return $urandom_range(13, 63);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      rsp_ch.ready <= 1'b0;
      ready_hold   <= idle_len() - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic issue(op_t op, int r, int c, bit v);
    cmd_t req;
    int   gap;
    req.opcode     = op;
    req.row        = COORD_W'(r);
    req.col        = COORD_W'(c);
    req.cell_value = v;
    case (op)
      OP_WRITE:  n_write++;
      OP_TOGGLE: n_toggle++;
      OP_READ:   n_read++;
      default:   n_step++;
    endcase
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= req;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 35)
      gap = idle_len();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= CFG_W'(val);
    if (idx == REG_ROWS_IN_USE) rows_now = val & 127;
    if (idx == REG_COLS_IN_USE) cols_now = val & 127;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stim
    int   n_rand;
    int   nr;
    int   nc;
    int   step_cap;
    int   steps;
    int   base_r;
    int   base_c;
    int   cnt;
    int   w;
    int   r;
    int   c;
    bit   noisy;
    op_t  op;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    wr_en          <= 1'b0;
    wr_index       <= '0;
    wr_data        <= '0;
    rst            <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // full grid after reset: corners, block still life, blinker against the edge
    issue(OP_WRITE, 0, 0, 1'b1);
    issue(OP_WRITE, 63, 63, 1'b1);
    issue(OP_TOGGLE, 0, 63, 1'b0);
    issue(OP_TOGGLE, 0, 63, 1'b1);
    issue(OP_READ, 63, 63, 1'b0);
    issue(OP_WRITE, 63, 63, 1'b0);
    issue(OP_WRITE, 0, 1, 1'b1);
    issue(OP_WRITE, 1, 0, 1'b1);
    issue(OP_WRITE, 1, 1, 1'b1);
    issue(OP_WRITE, 63, 61, 1'b1);
    issue(OP_WRITE, 63, 62, 1'b1);
    issue(OP_WRITE, 63, 63, 1'b1);
    issue(OP_STEP, 0, 0, 1'b0);
    issue(OP_READ, 1, 1, 1'b0);
    issue(OP_READ, 62, 62, 1'b0);
    issue(OP_STEP, 63, 63, 1'b1);

    // shrunk grid, accesses off the edge
    drain();
    write_reg(REG_ROWS_IN_USE, 3);
    write_reg(REG_COLS_IN_USE, 3);
    n_sizes++;
    issue(OP_TOGGLE, 5, 5, 1'b0);
    issue(OP_READ, 0, 3, 1'b0);
    issue(OP_WRITE, 3, 0, 1'b1);
    issue(OP_STEP, 0, 0, 1'b0);
    issue(OP_READ, 0, 0, 1'b0);

    // empty grid
    drain();
    write_reg(REG_ROWS_IN_USE, 0);
    n_sizes++;
    issue(OP_STEP, 0, 0, 1'b0);
    issue(OP_READ, 0, 0, 1'b0);

    // oversized sizes clip to the full grid, spare indexes have no effect
    drain();
    write_reg(REG_ROWS_IN_USE, 127);
    write_reg(REG_COLS_IN_USE, 100);
    write_reg(REG_SPARE2, 5);
    write_reg(REG_SPARE3, 42);
    n_sizes++;
    issue(OP_READ, 63, 63, 1'b0);
    issue(OP_READ, 2, 2, 1'b0);

    n_rand = 0;
    while (n_rand < 115) begin
      drain();
      repeat (2) @(posedge clk);
      if ($urandom_range(0, 99) < 85) write_reg(REG_ROWS_IN_USE, pick_size());
      if ($urandom_range(0, 99) < 85) write_reg(REG_COLS_IN_USE, pick_size());
      if ($urandom_range(0, 99) < 10)
        write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3, $urandom_range(0, 127));
      n_sizes++;
      quiet    = ($urandom_range(0, 4) == 0);
      noisy    = ($urandom_range(0, 3) == 0);
      nr       = (rows_now > 64) ? 64 : rows_now;
      nc       = (cols_now > 64) ? 64 : cols_now;
      step_cap = (nr * nc > 256) ? 2 : 8;
      steps    = 0;
      base_r   = (nr > 0) ? $urandom_range(0, nr - 1) : 0;
      base_c   = (nc > 0) ? $urandom_range(0, nc - 1) : 0;
      cnt      = $urandom_range(10, 24);
      for (int i = 0; i < cnt && n_rand < 115; i++) begin
        w = $urandom_range(0, 99);
        if (noisy)         op = op_t'($urandom_range(0, 3));
        else if (w < 35)   op = OP_WRITE;
        else if (w < 50)   op = OP_TOGGLE;
        else if (w < 75)   op = OP_READ;
        else               op = OP_STEP;
        if (op == OP_STEP) begin
          if (steps >= step_cap) op = OP_READ;
          else steps++;
        end
        if (noisy || nr == 0 || nc == 0 || $urandom_range(0, 99) < 8) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end else if (nr * nc <= 256) begin
          r = $urandom_range(0, nr - 1);
          c = $urandom_range(0, nc - 1);
        end else begin
          // dense cluster so that large grids still evolve
          r = (base_r + $urandom_range(0, 4)) % nr;
          c = (base_c + $urandom_range(0, 4)) % nc;
        end
        issue(op, r, c, $urandom_range(0, 99) < 75);
        n_rand++;
        if ($urandom_range(0, 99) < 3) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("run covered %0d writes, %0d toggles, %0d reads and %0d generation steps",
             n_write, n_toggle, n_read, n_step);
    $display("over %0d grid size settings, including empty, clipped and shrunk grids",
             n_sizes);
    if (pending != 0)
      $display("%0d results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("** life_automaton_grid_engine_top: PASSED **");
    end else begin
      $display("** life_automaton_grid_engine_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #48000000;
    $display("timeout with %0d results outstanding", pending);
    $display("** life_automaton_grid_engine_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lge_pkg.sv
hdl/lge_stream_if.sv
hdl/lge_row_mem.sv
hdl/lge_cell_unit.sv
hdl/life_automaton_grid_engine_top.sv
hdl/lge_checker.sv
tb/sv/lge_grid_checker.sv
tb/sv/tb_life_automaton_grid_engine_top.sv
